@@ hdl/mcfp_pkg.sv @@
// Shared types, codes and sizes for the MQTT CONNECT field parser.
// No dependencies; every other file of the block imports this package.
package mcfp_pkg;

    localparam int MAX_PACKET_DEF     = 256;
    localparam int FIELD_COPY_MAX_DEF = 63;
    localparam int MIN_PACKET         = 10;

    // result queue behind the parser core
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // width of index arithmetic; covers index plus a 16-bit field length
    localparam int IDX_W = 20;

    localparam logic [7:0] FLAG_USERNAME = 8'h80;
    localparam logic [7:0] FLAG_PASSWORD = 8'h40;
    localparam logic [8:0] POS_MAX       = 9'd511;

    localparam logic       KIND_CONTENT = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam logic [1:0] FID_CLIENT   = 2'd0;
    localparam logic [1:0] FID_USERNAME = 2'd1;
    localparam logic [1:0] FID_PASSWORD = 2'd2;

    localparam logic [1:0] ST_PARSED = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    // step within a length-prefixed field
    localparam logic [1:0] STEP_LEN_HI = 2'd0;
    localparam logic [1:0] STEP_LEN_LO = 2'd1;
    localparam logic [1:0] STEP_DATA   = 2'd2;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_PNL_LO,
        PH_FLAGS,
        PH_F0_HI,
        PH_F0_LO,
        PH_F0_DATA,
        PH_F1_HI,
        PH_F1_LO,
        PH_F1_DATA,
        PH_F2_HI,
        PH_F2_LO,
        PH_F2_DATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] total_length;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  field_id;
        logic [5:0]  field_offset;
        logic [7:0]  field_byte;
        logic [1:0]  parse_status;
        logic [17:0] end_offset;
        logic        run_last;
    } result_t;

    // words handed from the core to the queue in one cycle, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ hdl/mqtt_connect_field_parser.sv @@
// Top level of the MQTT CONNECT field parser: parser core plus result queue.
// Depends on mcfp_pkg, mcfp_core and mcfp_queue.
//
// Usage: feed the bytes of one received CONNECT packet on the item channel,
// one word per byte, each tagged with the packet's received length and with
// final_byte set on the last byte. The result channel carries content words
// (client id, username, password bytes, first FIELD_COPY_MAX of each field
// that lies wholly inside the received length) and one status word per
// packet, marked by run_last, with the parse status and end offset.
// Path: an accepted byte is held in the input register, decoded, and its
// results written to the queue once it has room, which offers them in order.
// Throughput: one byte per cycle while the queue has room. A final byte with
// content yields two words; the queue drains one per cycle if not stalled.
// Stall: item_stall rises when the input register holds a byte and the
// queue lacks space for two more words; it depends on no input port.
// When the receiver stalls, the queue fills and stops the input once it
// holds more than QUEUE_DEPTH-2 words; a stalled result word holds.
// Reset: rst_n clears the parser to the fixed header phase and empties the
// queue; the packet state also returns there after each final byte.
module mqtt_connect_field_parser #(
    parameter int MAX_PACKET     = mcfp_pkg::MAX_PACKET_DEF,
    parameter int FIELD_COPY_MAX = mcfp_pkg::FIELD_COPY_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mcfp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mcfp_pkg::result_t result
);
    import mcfp_pkg::*;

    push_t push;    // words from core to queue this cycle
    logic  room;    // queue can take two more words

    mcfp_core #(
        .MAX_PACKET     (MAX_PACKET),
        .FIELD_COPY_MAX (FIELD_COPY_MAX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .room       (room),
        .push       (push)
    );

    // decouple the receiver from the parser
    mcfp_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ hdl/mcfp_queue.sv @@
// Small result queue: takes up to two words a cycle, hands out one.
// Depends on mcfp_pkg (result_t, push_t, QUEUE_DEPTH).
module mcfp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  mcfp_pkg::push_t  push,
    output logic             room,
    output logic             result_valid,
    input  logic             result_stall,
    output mcfp_pkg::result_t result
);
    import mcfp_pkg::*;

    result_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  pop;

    assign result_valid = (count_reg != '0);
    assign result       = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // leave space for the two words one item can produce
    assign room         = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QUEUE_AW'(1)] <= push.second;
        end
    end

endmodule

@@ hdl/mcfp_core.sv @@
// Parser core: input register, per-byte state update and result build.
// Depends on mcfp_pkg (item_t, push_t, phase_t and the code constants).
module mcfp_core #(
    parameter int MAX_PACKET     = mcfp_pkg::MAX_PACKET_DEF,
    parameter int FIELD_COPY_MAX = mcfp_pkg::FIELD_COPY_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  mcfp_pkg::item_t item,
    input  logic            room,
    output mcfp_pkg::push_t push
);
    import mcfp_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    item_t              in_word_reg;

    phase_t             phase_reg, phase_next, phase_u;
    logic [8:0]         pos_reg, pos_next;
    logic [7:0]         len_hi_reg, len_hi_next, len_hi_u;
    logic [16:0]        rem_reg, rem_next, rem_u;
    logic [7:0]         flags_reg, flags_next, flags_u;
    logic [17:0]        pidx_reg, pidx_next, pidx_u;
    logic [1:0]         held_reg, held_next, held_u;

    logic               process;
    logic               accept;
    logic [8:0]         len;
    logic [IDX_W-1:0]   len_w;
    logic [IDX_W-1:0]   pos_w;
    logic [IDX_W-1:0]   pidx_w;
    logic [IDX_W-1:0]   off_w;
    logic [1:0]         fsel;
    logic [1:0]         step;
    logic               data_hit;
    logic               emit_en;

    assign item_stall = in_valid_reg && !room;
    assign accept     = item_valid && !item_stall;
    assign process    = in_valid_reg && room;

    always_comb
    begin
        in_valid_next = accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HDR;
            pos_reg      <= '0;
            len_hi_reg   <= '0;
            rem_reg      <= '0;
            flags_reg    <= '0;
            pidx_reg     <= '0;
            held_reg     <= ST_PARSED;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_hi_reg   <= len_hi_next;
            rem_reg      <= rem_next;
            flags_reg    <= flags_next;
            pidx_reg     <= pidx_next;
            held_reg     <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= item;
        end
    end

    // decode of the current phase and the data-byte hit
    always_comb
    begin
        len    = (32'(in_word_reg.total_length) > MAX_PACKET) ? 9'(MAX_PACKET)
                                                              : in_word_reg.total_length;
        len_w  = IDX_W'(len);
        pos_w  = IDX_W'(pos_reg);
        pidx_w = IDX_W'(pidx_reg);
        off_w  = pos_w - pidx_w;
        case (phase_reg)
            PH_F0_HI:   begin fsel = FID_CLIENT;   step = STEP_LEN_HI; end
            PH_F0_LO:   begin fsel = FID_CLIENT;   step = STEP_LEN_LO; end
            PH_F0_DATA: begin fsel = FID_CLIENT;   step = STEP_DATA;   end
            PH_F1_HI:   begin fsel = FID_USERNAME; step = STEP_LEN_HI; end
            PH_F1_LO:   begin fsel = FID_USERNAME; step = STEP_LEN_LO; end
            PH_F1_DATA: begin fsel = FID_USERNAME; step = STEP_DATA;   end
            PH_F2_HI:   begin fsel = FID_PASSWORD; step = STEP_LEN_HI; end
            PH_F2_LO:   begin fsel = FID_PASSWORD; step = STEP_LEN_LO; end
            PH_F2_DATA: begin fsel = FID_PASSWORD; step = STEP_DATA;   end
            default:    begin fsel = FID_CLIENT;   step = 2'd3;        end
        endcase
        data_hit = (step == STEP_DATA) && (pos_w >= pidx_w) && (rem_reg != '0);
        emit_en  = process && data_hit && (off_w < IDX_W'(FIELD_COPY_MAX));
    end

    // next state
    always_comb
    begin
        logic               fin_en;
        logic [1:0]         fin_st;
        logic [IDX_W-1:0]   fin_idx;
        logic               adv_en;
        logic [1:0]         adv_f;
        logic [IDX_W-1:0]   adv_idx;
        logic               keep_pw;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   flen;
        logic               fits;

        fin_en   = 1'b0;
        fin_st   = ST_PARSED;
        fin_idx  = '0;
        adv_en   = 1'b0;
        adv_f    = FID_CLIENT;
        adv_idx  = '0;
        keep_pw  = 1'b0;
        idx      = '0;
        flen     = '0;
        fits     = 1'b0;

        phase_u  = phase_reg;
        len_hi_u = len_hi_reg;
        rem_u    = rem_reg;
        flags_u  = flags_reg;
        pidx_u   = pidx_reg;
        held_u   = held_reg;

        if (process)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (pos_reg == 9'd0 && len < 9'(MIN_PACKET))
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_SHORT;
                    end
                    else if (pos_reg == 9'd2)
                    begin
                        len_hi_u = in_word_reg.data_byte;
                        phase_u  = PH_PNL_LO;
                    end
                end
                PH_PNL_LO:
                begin
                    if (pos_reg == 9'd3)
                    begin
                        idx = IDX_W'(4) + IDX_W'({len_hi_reg, in_word_reg.data_byte});
                        if (idx + IDX_W'(4) > len_w)
                        begin
                            fin_en = 1'b1;
                            fin_st = ST_TRUNC;
                        end
                        else
                        begin
                            pidx_u  = idx[17:0];
                            phase_u = PH_FLAGS;
                        end
                    end
                end
                PH_FLAGS:
                begin
                    if (pos_w == pidx_w + IDX_W'(1))
                    begin
                        idx     = pidx_w + IDX_W'(4);
                        flags_u = in_word_reg.data_byte;
                        if (idx + IDX_W'(2) > len_w)
                        begin
                            fin_en = 1'b1;
                            fin_st = ST_TRUNC;
                        end
                        else
                        begin
                            pidx_u  = idx[17:0];
                            phase_u = PH_F0_HI;
                        end
                    end
                end
                PH_DONE:
                begin
                    // ignore trailing bytes
                end
                default:
                begin
                    if (step == STEP_LEN_HI)
                    begin
                        if (pos_w == pidx_w)
                        begin
                            len_hi_u = in_word_reg.data_byte;
                            phase_u  = phase_t'(4'(phase_reg) + 4'd1);
                        end
                    end
                    else if (step == STEP_LEN_LO)
                    begin
                        if (pos_w == pidx_w + IDX_W'(1))
                        begin
                            flen  = IDX_W'({len_hi_reg, in_word_reg.data_byte});
                            idx   = pidx_w + IDX_W'(2);
                            fits  = (flen != '0) && (idx + flen <= len_w);
                            rem_u = flen[16:0];
                            if (fsel == FID_PASSWORD)
                            begin
                                fin_en  = 1'b1;
                                fin_st  = ST_PARSED;
                                fin_idx = idx;
                                keep_pw = fits;
                            end
                            else if (fits)
                            begin
                                pidx_u  = idx[17:0];
                                phase_u = phase_t'(4'(phase_reg) + 4'd1);
                            end
                            else
                            begin
                                adv_en  = 1'b1;
                                adv_f   = fsel;
                                adv_idx = idx + flen;
                            end
                        end
                    end
                    else if (data_hit)
                    begin
                        rem_u = rem_reg - 17'd1;
                        if (rem_reg == 17'd1)
                        begin
                            if (fsel == FID_PASSWORD)
                            begin
                                phase_u = PH_DONE;
                            end
                            else
                            begin
                                adv_en  = 1'b1;
                                adv_f   = fsel;
                                adv_idx = pos_w + IDX_W'(1);
                            end
                        end
                    end
                end
            endcase

            // move on to the next field the connect flags call for
            if (adv_en)
            begin
                if (adv_f == FID_CLIENT && (flags_reg & FLAG_USERNAME) != '0)
                begin
                    if (adv_idx + IDX_W'(2) > len_w)
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_TRUNC;
                    end
                    else
                    begin
                        pidx_u  = adv_idx[17:0];
                        phase_u = PH_F1_HI;
                    end
                end
                else if (adv_f != FID_PASSWORD && (flags_reg & FLAG_PASSWORD) != '0)
                begin
                    if (adv_idx + IDX_W'(2) > len_w)
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_TRUNC;
                    end
                    else
                    begin
                        pidx_u  = adv_idx[17:0];
                        phase_u = PH_F2_HI;
                    end
                end
                else
                begin
                    fin_en  = 1'b1;
                    fin_st  = ST_PARSED;
                    fin_idx = adv_idx;
                end
            end

            if (fin_en)
            begin
                phase_u = PH_DONE;
                held_u  = fin_st;
                pidx_u  = (fin_st == ST_PARSED) ? fin_idx[17:0] : '0;
            end

            // password fits: parse is complete, still copy its bytes
            if (keep_pw)
            begin
                phase_u = PH_F2_DATA;
            end
        end

        if (process && in_word_reg.final_byte)
        begin
            phase_next  = PH_HDR;
            pos_next    = '0;
            len_hi_next = '0;
            rem_next    = '0;
            flags_next  = '0;
            pidx_next   = '0;
            held_next   = ST_PARSED;
        end
        else
        begin
            phase_next  = phase_u;
            pos_next    = process ? ((pos_reg < POS_MAX) ? pos_reg + 9'd1 : POS_MAX)
                                  : pos_reg;
            len_hi_next = len_hi_u;
            rem_next    = rem_u;
            flags_next  = flags_u;
            pidx_next   = pidx_u;
            held_next   = held_u;
        end
    end

    // result words
    always_comb
    begin
        result_t content;
        result_t status;

        content              = '0;
        content.result_kind  = KIND_CONTENT;
        content.field_id     = fsel;
        content.field_offset = off_w[5:0];
        content.field_byte   = in_word_reg.data_byte;

        status               = '0;
        status.result_kind   = KIND_STATUS;
        status.run_last      = 1'b1;
        status.parse_status  = (phase_u != PH_DONE) ? ST_TRUNC : held_u;
        status.end_offset    = (status.parse_status == ST_PARSED) ? pidx_u : '0;

        push = '0;
        if (emit_en)
        begin
            push.first  = content;
            push.second = status;
            push.count  = (process && in_word_reg.final_byte) ? 2'd2 : 2'd1;
        end
        else
        begin
            push.first  = status;
            push.second = status;
            push.count  = (process && in_word_reg.final_byte) ? 2'd1 : 2'd0;
        end
    end

endmodule
